// ===== src/fbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types, constants and byte functions of the 128-bit Feistel cipher.
// ----------------------------------------------------------------------------
package fbc_pkg;

  // default round count
  localparam int ROUNDS_DEF = 8;

  // word and port widths
  localparam int HALF_W     = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_LEN_W  = 5;

  // configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_KEY_HIGH   = 2'd0;
  localparam cfg_idx_t REG_KEY_LOW    = 2'd1;
  localparam cfg_idx_t REG_KEY_LENGTH = 2'd2;

  // function codes
  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  // round function and schedule constants
  localparam logic [7:0] IDX_STEP   = 8'd17;
  localparam logic [7:0] IDX_BASE   = 8'd31;
  localparam logic [7:0] LOAD_STEP  = 8'd71;
  localparam logic [7:0] ROUND_STEP = 8'd43;
  localparam int         ROT_BYTES  = 5;

  // cipher datapath states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WHITEN,
    ST_ROUND,
    ST_FINAL
  } fbc_state_t;

  // key schedule states
  typedef enum logic [1:0] {
    KS_IDLE,
    KS_LOAD,
    KS_HI,
    KS_LO
  } ks_state_t;

  // 4-bit substitution
  function automatic logic [3:0] nib_sub(input logic [3:0] n);
    logic [3:0] s;
    case (n)
      4'h0: s = 4'hE;
      4'h1: s = 4'h4;
      4'h2: s = 4'hD;
      4'h3: s = 4'h1;
      4'h4: s = 4'h2;
      4'h5: s = 4'hF;
      4'h6: s = 4'hB;
      4'h7: s = 4'h8;
      4'h8: s = 4'h3;
      4'h9: s = 4'hA;
      4'hA: s = 4'h6;
      4'hB: s = 4'hC;
      4'hC: s = 4'h5;
      4'hD: s = 4'h9;
      4'hE: s = 4'h0;
      default: s = 4'h7;
    endcase
    return s;
  endfunction

  // byte substitution, both nibbles
  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    return {nib_sub(b[7:4]), nib_sub(b[3:0])};
  endfunction

  // round function over one 64-bit half, byte 0 on top
  function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] h,
                                                input logic [HALF_W-1:0] k);
    logic [0:7][7:0] hb;
    logic [0:7][7:0] kb;
    logic [0:7][7:0] ob;
    hb = h;
    kb = k;
    for (int i = 0; i < 8; i++) begin
      ob[i] = sub_byte(hb[i] ^ kb[i]) ^ (8'(i) * IDX_STEP + IDX_BASE)
              ^ kb[(i + 3) % 8];
    end
    return ob;
  endfunction

endpackage

// ===== src/fbc_if.sv =====
// ----------------------------------------------------------------------------
// fbc_in_if / fbc_out_if
// Valid/ready channels carrying block words into and out of the cipher.
// ----------------------------------------------------------------------------
interface fbc_in_if import fbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [HALF_W-1:0] block_high;
  logic [HALF_W-1:0] block_low;

  modport source (output valid, func, block_high, block_low, input ready);
  modport sink   (input valid, func, block_high, block_low, output ready);
endinterface

interface fbc_out_if import fbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] out_high;
  logic [HALF_W-1:0] out_low;

  modport source (output valid, out_high, out_low, input ready);
  modport sink   (input valid, out_high, out_low, output ready);
endinterface

// ===== src/fbc_keysched.sv =====
// ----------------------------------------------------------------------------
// fbc_keysched
// Key registers and round key generator; writes the round key memory.
// ----------------------------------------------------------------------------
module fbc_keysched import fbc_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  cfg_idx_t                 cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output logic                     busy,
  output logic                     wr_en,
  output logic [$clog2(ROUNDS+1):0] wr_addr,
  output logic [HALF_W-1:0]        wr_data
);

  localparam int RW = $clog2(ROUNDS + 1);

  // one in-place schedule pass over the 16 working bytes
  function automatic logic [0:15][7:0] sched_step(input logic [0:15][7:0] w,
                                                  input logic [7:0] c);
    logic [0:15][7:0] nw;
    for (int i = 0; i < 16 - ROT_BYTES; i++) begin
      nw[i] = sub_byte(w[i + ROT_BYTES] ^ (c + 8'(i)));
    end
    for (int i = 16 - ROT_BYTES; i < 16; i++) begin
      nw[i] = sub_byte(nw[i + ROT_BYTES - 16] ^ (c + 8'(i)));
    end
    return nw;
  endfunction

  ks_state_t              state_r, state_nxt;
  logic [HALF_W-1:0]      key_high_r, key_high_nxt;
  logic [HALF_W-1:0]      key_low_r, key_low_nxt;
  logic [KEY_LEN_W-1:0]   key_len_r, key_len_nxt;
  logic [0:15][7:0]       w_r, w_nxt;
  logic [3:0]             step_r, step_nxt;
  logic [3:0]             pos_r, pos_nxt;
  logic [7:0]             c71_r, c71_nxt;
  logic [7:0]             c43_r, c43_nxt;
  logic [RW-1:0]          rnd_r, rnd_nxt;
  logic [0:15][7:0]       key_b;
  logic [KEY_LEN_W-1:0]   len_eff;
  logic                   cfg_hit;

  assign key_b   = {key_high_r, key_low_r};
  assign cfg_hit = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW ||
                              cfg_index == REG_KEY_LENGTH);

  // clamp key length to 1..16
  always_comb begin
    if (key_len_r == '0) begin
      len_eff = KEY_LEN_W'(1);
    end else if (key_len_r > KEY_LEN_W'(16)) begin
      len_eff = KEY_LEN_W'(16);
    end else begin
      len_eff = key_len_r;
    end
  end

  // schedule sequencer
  always_comb begin
    state_nxt    = state_r;
    key_high_nxt = key_high_r;
    key_low_nxt  = key_low_r;
    key_len_nxt  = key_len_r;
    w_nxt        = w_r;
    step_nxt     = step_r;
    pos_nxt      = pos_r;
    c71_nxt      = c71_r;
    c43_nxt      = c43_r;
    rnd_nxt      = rnd_r;
    wr_en        = 1'b0;
    wr_addr      = {rnd_r, 1'b0};
    wr_data      = w_r[0:7];
    unique case (state_r)
      KS_IDLE: begin
      end
      // shift in key bytes cycled over the key length
      KS_LOAD: begin
        w_nxt    = {w_r[1:15], key_b[pos_r] ^ c71_r};
        c71_nxt  = c71_r + LOAD_STEP;
        step_nxt = step_r + 4'd1;
        pos_nxt  = ({1'b0, pos_r} + KEY_LEN_W'(1) == len_eff) ? '0 : pos_r + 4'd1;
        if (step_r == 4'd15) begin
          state_nxt = KS_HI;
          rnd_nxt   = '0;
          c43_nxt   = '0;
        end
      end
      KS_HI: begin
        wr_en     = 1'b1;
        state_nxt = KS_LO;
      end
      // store low word and advance the working bytes
      KS_LO: begin
        wr_en   = 1'b1;
        wr_addr = {rnd_r, 1'b1};
        wr_data = w_r[8:15];
        w_nxt   = sched_step(w_r, c43_r);
        c43_nxt = c43_r + ROUND_STEP;
        if (rnd_r == RW'(ROUNDS)) begin
          state_nxt = KS_IDLE;
        end else begin
          rnd_nxt   = rnd_r + RW'(1);
          state_nxt = KS_HI;
        end
      end
      default: state_nxt = KS_IDLE;
    endcase
    // register write restarts the schedule
    if (cfg_hit) begin
      state_nxt = KS_LOAD;
      step_nxt  = '0;
      pos_nxt   = '0;
      c71_nxt   = '0;
      case (cfg_index)
        REG_KEY_HIGH:   key_high_nxt = cfg_data;
        REG_KEY_LOW:    key_low_nxt  = cfg_data;
        default:        key_len_nxt  = cfg_data[KEY_LEN_W-1:0];
      endcase
    end
  end

  assign busy = (state_r != KS_IDLE);

  // control and key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= KS_IDLE;
      key_high_r <= '0;
      key_low_r  <= '0;
      key_len_r  <= KEY_LEN_W'(16);
      step_r     <= '0;
      pos_r      <= '0;
      rnd_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      key_high_r <= key_high_nxt;
      key_low_r  <= key_low_nxt;
      key_len_r  <= key_len_nxt;
      step_r     <= step_nxt;
      pos_r      <= pos_nxt;
      rnd_r      <= rnd_nxt;
    end
  end

  // working bytes and byte counters
  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    c71_r <= c71_nxt;
    c43_r <= c43_nxt;
  end

endmodule

// ===== src/feistel_block_cipher_128.sv =====
// A block passes input whitening, the Feistel rounds (one a cycle, each fed by one key
// memory read) and output whitening into the result register. A new block is taken
// only when the previous result can be written. A key register write runs the schedule,
// loading key bytes and then writing round keys, with input not ready meanwhile. Sync
// reset clears control registers and key words and sets the key length to 16; round
// key memory holds nothing usable until the first key register write.
// ----------------------------------------------------------------------------
// feistel_block_cipher_128
// 128-bit Feistel cipher with whitening, round keys held in one memory.
// ----------------------------------------------------------------------------
module feistel_block_cipher_128 import fbc_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fbc_in_if.sink                in_ch,
  fbc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RW        = $clog2(ROUNDS + 1);
  localparam int AW        = RW + 1;
  localparam int NUM_WORDS = 2 * (ROUNDS + 1);

  fbc_state_t        state_r, state_nxt;
  logic              func_r, func_nxt;
  logic [HALF_W-1:0] l_r, l_nxt;
  logic [HALF_W-1:0] r_r, r_nxt;
  logic [RW-1:0]     k_r, k_nxt;
  logic [RW-1:0]     cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [HALF_W-1:0] out_high_r, out_high_nxt;
  logic [HALF_W-1:0] out_low_r, out_low_nxt;

  logic              ks_busy;
  logic              ks_wr_en;
  logic [AW-1:0]     ks_wr_addr;
  logic [HALF_W-1:0] ks_wr_data;

  logic [HALF_W-1:0] key_mem [NUM_WORDS];
  logic              rd_en;
  logic [RW-1:0]     rd_row;
  logic [HALF_W-1:0] q_a, q_b;

  logic              out_free;
  logic              accept;
  logic [HALF_W-1:0] f_val;

  // key schedule
  fbc_keysched #(.ROUNDS(ROUNDS)) u_keysched (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (ks_busy),
    .wr_en     (ks_wr_en),
    .wr_addr   (ks_wr_addr),
    .wr_data   (ks_wr_data)
  );

  // round key memory, even word and odd word of one row read together
  always_ff @(posedge clk) begin
    if (ks_wr_en) begin
      key_mem[ks_wr_addr] <= ks_wr_data;
    end
    if (rd_en) begin
      q_a <= key_mem[{rd_row, 1'b0}];
      q_b <= key_mem[{rd_row, 1'b1}];
    end
  end

  // handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !ks_busy && !cfg_we &&
                       (state_r == ST_IDLE || (state_r == ST_FINAL && out_free));
  assign accept      = in_ch.valid && in_ch.ready;

  // round function on the half that feeds it
  assign f_val = round_f((func_r == FUNC_DEC) ? l_r : r_r, q_a);

  // datapath sequencer
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    rd_en         = 1'b0;
    rd_row        = k_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_high_nxt  = out_high_r;
    out_low_nxt   = out_low_r;
    unique case (state_r)
      ST_IDLE: begin
      end
      // input whitening, fetch first round key
      ST_WHITEN: begin
        l_nxt     = l_r ^ q_a;
        r_nxt     = r_r ^ q_b;
        k_nxt     = (func_r == FUNC_DEC) ? RW'(ROUNDS) : RW'(1);
        rd_en     = 1'b1;
        rd_row    = k_nxt;
        cnt_nxt   = RW'(ROUNDS);
        state_nxt = ST_ROUND;
      end
      // one Feistel round, fetch next key or final whitening row
      ST_ROUND: begin
        if (func_r == FUNC_DEC) begin
          l_nxt = r_r ^ f_val;
          r_nxt = l_r;
        end else begin
          l_nxt = r_r;
          r_nxt = l_r ^ f_val;
        end
        rd_en = 1'b1;
        if (cnt_r == RW'(1)) begin
          rd_row    = (func_r == FUNC_DEC) ? '0 : RW'(ROUNDS);
          state_nxt = ST_FINAL;
        end else begin
          k_nxt   = (func_r == FUNC_DEC) ? k_r - RW'(1) : k_r + RW'(1);
          rd_row  = k_nxt;
          cnt_nxt = cnt_r - RW'(1);
        end
      end
      // output whitening into the result register
      ST_FINAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_high_nxt  = l_r ^ q_a;
          out_low_nxt   = r_r ^ q_b;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // take a new block, fetch its input whitening row
    if (accept) begin
      func_nxt  = in_ch.func;
      l_nxt     = in_ch.block_high;
      r_nxt     = in_ch.block_low;
      rd_en     = 1'b1;
      rd_row    = (in_ch.func == FUNC_DEC) ? RW'(ROUNDS) : '0;
      state_nxt = ST_WHITEN;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    out_high_r <= out_high_nxt;
    out_low_r  <= out_low_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_high = out_high_r;
  assign out_ch.out_low  = out_low_r;

endmodule

// ===== src/fbc_checker.sv =====
// ----------------------------------------------------------------------------
// fbc_checker
// Port-level checks of the Feistel cipher, bound to the top level.
// ----------------------------------------------------------------------------
module fbc_checker import fbc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [HALF_W-1:0] out_high,
  input logic [HALF_W-1:0] out_low,
  input logic              cfg_we,
  input cfg_idx_t          cfg_index
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low))
    else $error("result word changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a key register write starts the schedule and blocks input
  a_sched_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW ||
               cfg_index == REG_KEY_LENGTH) |=> !in_ready)
    else $error("input ready while key schedule runs");

  // one block in flight at a time
  a_one_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accepting a word");

endmodule

bind feistel_block_cipher_128 fbc_checker u_fbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_high  (out_ch.out_high),
  .out_low   (out_ch.out_low),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index)
);
